@@ hdl/lfukvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfukvc_pkg
// Shared types and constants for the LFU key-value cache.
// ----------------------------------------------------------------------------
package lfukvc_pkg;

  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CfgW = 5;

  // Request operation codes
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  // Value returned by a get that misses (-1)
  localparam logic signed [ValW-1:0] ReadMiss = '1;

  typedef struct packed {
    logic                   operation;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic signed [ValW-1:0] read_value;
    logic                   evicted;
    logic signed [KeyW-1:0] evicted_key;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, clear trackers
    logic scan;    // issue one read of the lookup sweep
    logic decide;  // register the update plan
    logic age;     // issue one read of the recency sweep
    logic commit;  // write the target entry
    logic emit;    // load the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;  // sweep index sits on the last entry
    logic upd;         // request changes the table
    logic out_free;    // output register can take a result
  } ctl_sts_t;

endpackage

@@ hdl/lfu_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lfu_key_value_cache
// Key-value cache with least-frequently-used replacement, oldest first
// among equal use counts.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid_i/in_stall_o    in_req_i   (req_t)
//  out       output     out_valid_o/out_stall_i  out_rsp_o  (rsp_t)
//  cfg       input      cfg_valid_i/cfg_ready_o  cfg_data_i (capacity_in_use)
//
//  One request at a time. A request that changes the table runs a lookup
//  sweep, then a recency sweep and a commit; a get miss or a put at zero
//  capacity skips both. The single read port of the entry tables sets the
//  two sweeps: one finds the key and victim, the other updates ranks.
//  Reset clears the valid bits, occupancy and sets capacity_in_use to 16.
//  A stalled result holds in the output register; the next request may
//  still be accepted and runs until its result is ready.
// ----------------------------------------------------------------------------
module lfu_key_value_cache
  import lfukvc_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  req_t            in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rsp_t            out_rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  ctl_cmd_t        cmd;
  ctl_sts_t        sts;
  logic [CfgW-1:0] cap_q;

  // Capacity register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CfgW'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  lfukvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfukvc_dp #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (in_req_i),
    .cap_cfg_i   (cap_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rsp_o       (out_rsp_o)
  );

endmodule

@@ hdl/lfukvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfukvc_ctrl
// Request sequencer: lookup sweep, plan, recency sweep, commit, respond.
// ----------------------------------------------------------------------------
module lfukvc_ctrl
  import lfukvc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StDrain  = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;
  localparam logic [2:0] StAge    = 3'd4;
  localparam logic [2:0] StCommit = 3'd5;
  localparam logic [2:0] StDone   = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.sweep_last) state_d = StDrain;
      end
      StDrain: begin
        state_d = StDecide;
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.upd ? StAge : StDone;
      end
      StAge: begin
        cmd_o.age = 1'b1;
        if (sts_i.sweep_last) state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

@@ hdl/lfukvc_dp.sv @@
// ----------------------------------------------------------------------------
// lfukvc_dp
// Entry tables, sweep index, lookup and victim trackers, recency update and
// output register.
// ----------------------------------------------------------------------------
module lfukvc_dp
  import lfukvc_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctl_cmd_t        cmd_i,
  output ctl_sts_t        sts_o,
  input  req_t            req_i,
  input  logic [CfgW-1:0] cap_cfg_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rsp_t            rsp_o
);

  localparam int IdxW  = $clog2(CAPACITY);
  localparam int UsedW = $clog2(CAPACITY + 1);
  localparam int CntW  = COUNT_WIDTH;

  // Entry tables
  logic [KeyW-1:0] key_mem  [CAPACITY];
  logic [ValW-1:0] val_mem  [CAPACITY];
  logic [CntW-1:0] cnt_mem  [CAPACITY];
  logic [IdxW-1:0] rank_mem [CAPACITY];

  logic [CAPACITY-1:0] valid_q;
  logic [UsedW-1:0]    used_q;

  req_t            req_q;
  logic [IdxW-1:0] idx_q;
  logic            sweep;
  logic            p_scan_q, p_age_q;
  logic [IdxW-1:0] p_addr_q;

  logic [KeyW-1:0] rd_key_q;
  logic [ValW-1:0] rd_val_q;
  logic [CntW-1:0] rd_cnt_q;
  logic [IdxW-1:0] rd_rank_q;
  logic            rd_valid;

  // Trackers of the lookup sweep
  logic            found_q;
  logic [IdxW-1:0] found_idx_q;
  logic [ValW-1:0] found_val_q;
  logic [CntW-1:0] found_cnt_q;
  logic [IdxW-1:0] found_rank_q;
  logic            vic_q;
  logic [IdxW-1:0] vic_idx_q;
  logic [CntW-1:0] vic_cnt_q;
  logic [IdxW-1:0] vic_rank_q;
  logic [KeyW-1:0] vic_key_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;

  // Plan
  logic            ins_q, evict_q, age_all_q;
  logic [IdxW-1:0] tgt_q, ref_rank_q;
  logic [ValW-1:0] plan_val_q;
  logic [CntW-1:0] plan_cnt_q;
  rsp_t            plan_rsp_q;

  logic            d_upd, d_ins, d_evict, d_age_all;
  logic [IdxW-1:0] d_tgt, d_ref;
  logic [ValW-1:0] d_val;
  logic [CntW-1:0] d_cnt;
  rsp_t            d_rsp;
  logic [UsedW-1:0] cap_eff;
  logic            is_put;
  logic            full;
  logic [CntW-1:0] cnt_inc;

  logic            out_valid_q;
  rsp_t            out_rsp_q;

  logic            rank_we;
  logic [IdxW-1:0] rank_wd;

  assign sweep    = cmd_i.scan | cmd_i.age;
  assign rd_valid = valid_q[p_addr_q];

  // Advance the sweep index, wrap after the last entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      p_scan_q <= 1'b0;
      p_age_q  <= 1'b0;
    end else begin
      p_scan_q <= cmd_i.scan;
      p_age_q  <= cmd_i.age;
      if (sweep) begin
        idx_q <= sts_o.sweep_last ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_addr_q <= idx_q;
    if (cmd_i.load) req_q <= req_i;
  end

  // Key, value and count tables: registered read, write at commit
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[idx_q];
    rd_val_q <= val_mem[idx_q];
    rd_cnt_q <= cnt_mem[idx_q];
    if (cmd_i.commit) begin
      key_mem[tgt_q] <= req_q.key;
      val_mem[tgt_q] <= plan_val_q;
      cnt_mem[tgt_q] <= plan_cnt_q;
    end
  end

  // Recency: target becomes newest, entries newer than reference (or all) age
  always_comb begin
    rank_we = 1'b0;
    rank_wd = rd_rank_q + IdxW'(1);
    if (p_age_q) begin
      if (p_addr_q == tgt_q) begin
        rank_we = 1'b1;
        rank_wd = '0;
      end else if (rd_valid && (age_all_q || (rd_rank_q < ref_rank_q))) begin
        rank_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_rank_q <= rank_mem[idx_q];
    if (rank_we) rank_mem[p_addr_q] <= rank_wd;
  end

  // Lookup sweep: first match, victim, first free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      vic_q   <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
      vic_q   <= 1'b0;
      free_q  <= 1'b0;
    end else if (p_scan_q) begin
      if (rd_valid && (rd_key_q == req_q.key) && !found_q) found_q <= 1'b1;
      if (rd_valid) vic_q <= 1'b1;
      if (!rd_valid) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_scan_q) begin
      if (rd_valid && (rd_key_q == req_q.key) && !found_q) begin
        found_idx_q  <= p_addr_q;
        found_val_q  <= rd_val_q;
        found_cnt_q  <= rd_cnt_q;
        found_rank_q <= rd_rank_q;
      end
      if (rd_valid && (!vic_q || (rd_cnt_q < vic_cnt_q) ||
                       ((rd_cnt_q == vic_cnt_q) && (rd_rank_q > vic_rank_q)))) begin
        vic_idx_q  <= p_addr_q;
        vic_cnt_q  <= rd_cnt_q;
        vic_rank_q <= rd_rank_q;
        vic_key_q  <= rd_key_q;
      end
      if (!rd_valid && !free_q) free_idx_q <= p_addr_q;
    end
  end

  // Plan the update from the sweep results
  always_comb begin
    if (int'(cap_cfg_i) > CAPACITY) cap_eff = UsedW'(CAPACITY);
    else                            cap_eff = UsedW'(cap_cfg_i);
    is_put  = (req_q.operation == OpPut);
    full    = (used_q >= cap_eff);
    cnt_inc = (&found_cnt_q) ? found_cnt_q : found_cnt_q + CntW'(1);

    d_upd     = 1'b0;
    d_ins     = 1'b0;
    d_evict   = 1'b0;
    d_age_all = 1'b0;
    d_tgt     = found_idx_q;
    d_ref     = found_rank_q;
    d_val     = found_val_q;
    d_cnt     = cnt_inc;

    d_rsp.hit         = found_q;
    d_rsp.read_value  = '0;
    d_rsp.evicted     = 1'b0;
    d_rsp.evicted_key = '0;

    if (!is_put) begin
      if (found_q) begin
        d_upd            = 1'b1;
        d_rsp.read_value = found_val_q;
      end else begin
        d_rsp.read_value = ReadMiss;
      end
    end else if (cap_eff != '0) begin
      d_val = req_q.value;
      if (found_q) begin
        d_upd = 1'b1;
      end else begin
        d_cnt = CntW'(1);
        if (full && vic_q) begin
          d_upd             = 1'b1;
          d_ins             = 1'b1;
          d_evict           = 1'b1;
          d_ref             = vic_rank_q;
          d_tgt             = (free_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q;
          d_rsp.evicted     = 1'b1;
          d_rsp.evicted_key = vic_key_q;
        end else if (free_q) begin
          d_upd     = 1'b1;
          d_ins     = 1'b1;
          d_age_all = 1'b1;
          d_tgt     = free_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      ins_q      <= d_ins;
      evict_q    <= d_evict;
      age_all_q  <= d_age_all;
      tgt_q      <= d_tgt;
      ref_rank_q <= d_ref;
      plan_val_q <= d_val;
      plan_cnt_q <= d_cnt;
      plan_rsp_q <= d_rsp;
    end
  end

  // Commit occupancy: mark the new entry, drop the victim
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
    end else if (cmd_i.commit && ins_q) begin
      valid_q[tgt_q] <= 1'b1;
      if (evict_q && (vic_idx_q != tgt_q)) valid_q[vic_idx_q] <= 1'b0;
      if (!evict_q) used_q <= used_q + UsedW'(1);
    end
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_rsp_q <= plan_rsp_q;
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = out_rsp_q;

  assign sts_o.sweep_last = (idx_q == IdxW'(CAPACITY - 1));
  assign sts_o.upd        = d_upd;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule
